>>> design/hcm_pkg.sv
// ----------------------------------------------------------------------------
// hcm_pkg
// Shared constants and types of the hypergraph cut metrics block.
// ----------------------------------------------------------------------------
package hcm_pkg;

  // Default sizes of the block.
  localparam int unsigned DefParts        = 16;
  localparam int unsigned DefPinCountBits = 16;
  localparam int unsigned DefWeightBits   = 16;
  localparam int unsigned DefSumBits      = 48;

  // Fixed port widths.
  localparam int unsigned PartBits     = 4;
  localparam int unsigned WeightInBits = 16;
  localparam int unsigned SpanOutBits  = 5;
  localparam int unsigned TotalBits    = 48;

  // Control bits that travel with a beat down the pipeline.
  typedef struct packed {
    logic clr;  // Clear beat: zero all totals, no result.
    logic cut;  // Finished net spans differing partition codes.
  } hcm_ctl_t;

endpackage

>>> design/hypergraph_cut_metrics.sv
// ----------------------------------------------------------------------------
// hypergraph_cut_metrics
// Streaming cut, connectivity (k-1) and sum-of-external-degrees totals of a
// partitioned hypergraph, fed one pin per beat.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake             | Beat
//   --------+-----------------------+---------------------------------------
//   in      | in_valid_i/in_ready_o | one pin, or a clear command (op_i = 1)
//   out     | out_valid_o/out_ready_i | per-net flags and the three totals
//
// The block takes one beat per cycle while in_ready_o is high. A pin moves
// through four registers: the input register, the per-net summary
// register, the product register behind the two multipliers, and the
// result register holding the totals. Reset clears all totals and all
// per-net state. While the result register is held, the pipeline keeps
// accepting until its free stages are full; pins that finish no net do not
// leave the tracker and never stall.
//
module hypergraph_cut_metrics #(
  parameter int unsigned PARTS          = hcm_pkg::DefParts,
  parameter int unsigned PIN_COUNT_BITS = hcm_pkg::DefPinCountBits,
  parameter int unsigned WEIGHT_BITS    = hcm_pkg::DefWeightBits,
  parameter int unsigned SUM_BITS       = hcm_pkg::DefSumBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [hcm_pkg::PartBits-1:0]      part_i,
  input  logic                              part_valid_i,
  input  logic [hcm_pkg::WeightInBits-1:0]  net_weight_i,
  input  logic                              net_global_i,
  input  logic                              last_pin_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              net_is_cut_o,
  output logic [hcm_pkg::SpanOutBits-1:0]   parts_spanned_o,
  output logic [hcm_pkg::TotalBits-1:0]     total_cut_o,
  output logic [hcm_pkg::TotalBits-1:0]     total_connectivity_o,
  output logic [hcm_pkg::TotalBits-1:0]     total_soed_o
);
  import hcm_pkg::*;

  localparam int unsigned SpanW = $clog2(PARTS + 1);
  localparam int unsigned ConnW = WEIGHT_BITS + SpanW;
  localparam int unsigned SoedW = WEIGHT_BITS + PIN_COUNT_BITS;

  // Tracker to weighing stage.
  logic                      sum_valid;
  logic                      sum_ready;
  hcm_ctl_t                  sum_ctl;
  logic [SpanW-1:0]          sum_span;
  logic [WEIGHT_BITS-1:0]    sum_weight;
  logic [PIN_COUNT_BITS-1:0] sum_ext;

  // Weighing stage to accumulators.
  logic                      prod_valid;
  hcm_ctl_t                  prod_ctl;
  logic [SpanW-1:0]          prod_span;
  logic [WEIGHT_BITS-1:0]    cut_add;
  logic [ConnW-1:0]          conn_add;
  logic [SoedW-1:0]          soed_add;

  logic                      acc_ready;
  logic                      acc_fire;
  logic                      out_valid_q;
  logic                      cut_q;
  logic [SpanOutBits-1:0]    span_q;
  logic [SUM_BITS-1:0]       cut_sum;
  logic [SUM_BITS-1:0]       conn_sum;
  logic [SUM_BITS-1:0]       soed_sum;

  hcm_net_tracker #(
    .PARTS          (PARTS),
    .PIN_COUNT_BITS (PIN_COUNT_BITS),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .part_i       (part_i),
    .part_valid_i (part_valid_i),
    .net_weight_i (net_weight_i),
    .net_global_i (net_global_i),
    .last_pin_i   (last_pin_i),
    .sum_valid_o  (sum_valid),
    .sum_ready_i  (sum_ready),
    .sum_ctl_o    (sum_ctl),
    .sum_span_o   (sum_span),
    .sum_weight_o (sum_weight),
    .sum_ext_o    (sum_ext)
  );

  hcm_weigh #(
    .PARTS          (PARTS),
    .PIN_COUNT_BITS (PIN_COUNT_BITS),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_weigh (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sum_valid_i  (sum_valid),
    .sum_ready_o  (sum_ready),
    .sum_ctl_i    (sum_ctl),
    .sum_span_i   (sum_span),
    .sum_weight_i (sum_weight),
    .sum_ext_i    (sum_ext),
    .prod_valid_o (prod_valid),
    .prod_ready_i (acc_ready),
    .prod_ctl_o   (prod_ctl),
    .prod_span_o  (prod_span),
    .cut_add_o    (cut_add),
    .conn_add_o   (conn_add),
    .soed_add_o   (soed_add)
  );

  // The totals double as the result register, so they may only move when
  // the previous result has been taken or is being taken now.
  assign acc_ready = ~out_valid_q | out_ready_i;
  assign acc_fire  = prod_valid & acc_ready;

  hcm_sat_acc #(
    .SUM_BITS (SUM_BITS),
    .ADD_BITS (WEIGHT_BITS)
  ) u_acc_cut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (acc_fire),
    .clr_i  (prod_ctl.clr),
    .add_i  (cut_add),
    .sum_o  (cut_sum)
  );

  hcm_sat_acc #(
    .SUM_BITS (SUM_BITS),
    .ADD_BITS (ConnW)
  ) u_acc_conn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (acc_fire),
    .clr_i  (prod_ctl.clr),
    .add_i  (conn_add),
    .sum_o  (conn_sum)
  );

  hcm_sat_acc #(
    .SUM_BITS (SUM_BITS),
    .ADD_BITS (SoedW)
  ) u_acc_soed (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (acc_fire),
    .clr_i  (prod_ctl.clr),
    .add_i  (soed_add),
    .sum_o  (soed_sum)
  );

  // A clear beat updates the totals but produces no result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc_ready) begin
      out_valid_q <= prod_valid & ~prod_ctl.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_fire && !prod_ctl.clr) begin
      cut_q  <= prod_ctl.cut;
      span_q <= SpanOutBits'(prod_span);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign net_is_cut_o         = cut_q;
  assign parts_spanned_o      = span_q;
  assign total_cut_o          = TotalBits'(cut_sum);
  assign total_connectivity_o = TotalBits'(conn_sum);
  assign total_soed_o         = TotalBits'(soed_sum);

`ifndef SYNTHESIS
  // Two distinct valid partitions in one net always make it cut.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (parts_spanned_o > SpanOutBits'(1))) |-> net_is_cut_o)
    else $error("net spans several partitions but is not flagged as cut");

  // A clear beat taken by the accumulators zeroes all totals and yields
  // no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prod_valid && prod_ctl.clr && acc_ready) |=>
      (!out_valid_o && (total_cut_o == '0) && (total_connectivity_o == '0) &&
       (total_soed_o == '0)))
    else $error("clear did not zero the totals");
`endif

endmodule

>>> design/hcm_net_tracker.sv
// ----------------------------------------------------------------------------
// hcm_net_tracker
// Input register and per-net state; emits one summary beat per finished
// non-global net and one beat per clear command.
// ----------------------------------------------------------------------------
module hcm_net_tracker #(
  parameter int unsigned PARTS          = hcm_pkg::DefParts,
  parameter int unsigned PIN_COUNT_BITS = hcm_pkg::DefPinCountBits,
  parameter int unsigned WEIGHT_BITS    = hcm_pkg::DefWeightBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic [hcm_pkg::PartBits-1:0]        part_i,
  input  logic                                part_valid_i,
  input  logic [hcm_pkg::WeightInBits-1:0]    net_weight_i,
  input  logic                                net_global_i,
  input  logic                                last_pin_i,
  output logic                                sum_valid_o,
  input  logic                                sum_ready_i,
  output hcm_pkg::hcm_ctl_t                   sum_ctl_o,
  output logic [$clog2(PARTS+1)-1:0]          sum_span_o,
  output logic [WEIGHT_BITS-1:0]              sum_weight_o,
  output logic [PIN_COUNT_BITS-1:0]           sum_ext_o
);
  import hcm_pkg::*;

  localparam int unsigned IdxW  = $clog2(PARTS);
  localparam int unsigned CodeW = $clog2(PARTS + 1);
  localparam int unsigned SpanW = $clog2(PARTS + 1);
  localparam logic [PIN_COUNT_BITS-1:0] CntMax = '1;

  // Input register.
  logic                    iv_q;
  logic                    op_q;
  logic [PartBits-1:0]     part_q;
  logic                    pv_q;
  logic [WeightInBits-1:0] w_q;
  logic                    glob_q;
  logic                    last_q;

  // Per-net state. The seen bitmap doubles as valid bits of the counts.
  logic                      in_net_q;
  logic                      differs_q;
  logic [CodeW-1:0]          first_q;
  logic [PARTS-1:0]          seen_q;
  logic [SpanW-1:0]          span_q;
  logic [PIN_COUNT_BITS-1:0] max_q;
  logic [PIN_COUNT_BITS-1:0] pins_q;
  logic [PIN_COUNT_BITS-1:0] cnt_q [PARTS];

  logic                      sum_valid_q;
  hcm_ctl_t                  sum_ctl_q;
  logic [SpanW-1:0]          sum_span_q;
  logic [WEIGHT_BITS-1:0]    sum_weight_q;
  logic [PIN_COUNT_BITS-1:0] sum_ext_q;

  logic                      emits;
  logic                      slot_free;
  logic                      take;
  logic                      pin_ok;
  logic [IdxW-1:0]           idx;
  logic [CodeW-1:0]          code;
  logic [PIN_COUNT_BITS-1:0] cnt_old;
  logic [PIN_COUNT_BITS-1:0] cnt_new;
  logic [PARTS-1:0]          hit;
  logic                      differs_d;
  logic [CodeW-1:0]          first_d;
  logic [PARTS-1:0]          seen_d;
  logic [SpanW-1:0]          span_d;
  logic [PIN_COUNT_BITS-1:0] max_d;
  logic [PIN_COUNT_BITS-1:0] pins_d;

  // Clear commands and last pins of ordinary nets need a summary slot.
  assign emits     = op_q | (~glob_q & last_q);
  assign slot_free = ~sum_valid_q | sum_ready_i;
  assign take      = iv_q & (~emits | slot_free);
  assign in_ready_o = ~iv_q | take;

  // A partition number beyond the configured count counts as unassigned.
  assign pin_ok = pv_q && (int'(part_q) < PARTS);
  assign idx    = IdxW'(part_q);
  assign code   = pin_ok ? CodeW'(part_q) : CodeW'(PARTS);

  always_comb begin
    hit = '0;
    cnt_old = '0;
    if (pin_ok) begin
      hit[idx] = 1'b1;
      if (seen_q[idx]) begin
        cnt_old = cnt_q[idx];
      end
    end
    cnt_new   = (cnt_old == CntMax) ? cnt_old : cnt_old + 1'b1;
    pins_d    = (pins_q == CntMax) ? pins_q : pins_q + 1'b1;
    differs_d = in_net_q ? (differs_q | (code != first_q)) : 1'b0;
    first_d   = in_net_q ? first_q : code;
    seen_d    = seen_q | hit;
    span_d    = span_q + SpanW'(pin_ok && !seen_q[idx]);
    max_d     = (pin_ok && (cnt_new > max_q)) ? cnt_new : max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_ready_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_i;
      part_q <= part_i;
      pv_q   <= part_valid_i;
      w_q    <= net_weight_i;
      glob_q <= net_global_i;
      last_q <= last_pin_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_net_q  <= 1'b0;
      differs_q <= 1'b0;
      first_q   <= '0;
      seen_q    <= '0;
      span_q    <= '0;
      max_q     <= '0;
      pins_q    <= '0;
    end else if (take) begin
      if (op_q || last_q) begin
        // Clear command, end of any net, or a global net's last pin.
        in_net_q  <= 1'b0;
        differs_q <= 1'b0;
        first_q   <= '0;
        seen_q    <= '0;
        span_q    <= '0;
        max_q     <= '0;
        pins_q    <= '0;
      end else if (!glob_q) begin
        in_net_q  <= 1'b1;
        differs_q <= differs_d;
        first_q   <= first_d;
        seen_q    <= seen_d;
        span_q    <= span_d;
        max_q     <= max_d;
        pins_q    <= pins_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !op_q && !glob_q && pin_ok) begin
      cnt_q[idx] <= cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (slot_free) begin
      sum_valid_q <= take & emits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emits) begin
      sum_ctl_q.clr <= op_q;
      sum_ctl_q.cut <= differs_d;
      sum_span_q    <= span_d;
      sum_weight_q  <= WEIGHT_BITS'(w_q);
      sum_ext_q     <= pins_d - max_d;
    end
  end

  assign sum_valid_o  = sum_valid_q;
  assign sum_ctl_o    = sum_ctl_q;
  assign sum_span_o   = sum_span_q;
  assign sum_weight_o = sum_weight_q;
  assign sum_ext_o    = sum_ext_q;

endmodule

>>> design/hcm_weigh.sv
// ----------------------------------------------------------------------------
// hcm_weigh
// Weighs a finished net: cut addend, connectivity and external-pin products.
// ----------------------------------------------------------------------------
module hcm_weigh #(
  parameter int unsigned PARTS          = hcm_pkg::DefParts,
  parameter int unsigned PIN_COUNT_BITS = hcm_pkg::DefPinCountBits,
  parameter int unsigned WEIGHT_BITS    = hcm_pkg::DefWeightBits
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          sum_valid_i,
  output logic                                          sum_ready_o,
  input  hcm_pkg::hcm_ctl_t                             sum_ctl_i,
  input  logic [$clog2(PARTS+1)-1:0]                    sum_span_i,
  input  logic [WEIGHT_BITS-1:0]                        sum_weight_i,
  input  logic [PIN_COUNT_BITS-1:0]                     sum_ext_i,
  output logic                                          prod_valid_o,
  input  logic                                          prod_ready_i,
  output hcm_pkg::hcm_ctl_t                             prod_ctl_o,
  output logic [$clog2(PARTS+1)-1:0]                    prod_span_o,
  output logic [WEIGHT_BITS-1:0]                        cut_add_o,
  output logic [WEIGHT_BITS+$clog2(PARTS+1)-1:0]        conn_add_o,
  output logic [WEIGHT_BITS+PIN_COUNT_BITS-1:0]         soed_add_o
);
  import hcm_pkg::*;

  localparam int unsigned SpanW = $clog2(PARTS + 1);
  localparam int unsigned ConnW = WEIGHT_BITS + SpanW;
  localparam int unsigned SoedW = WEIGHT_BITS + PIN_COUNT_BITS;

  logic             pv_q;
  hcm_ctl_t         ctl_q;
  logic [SpanW-1:0] span_q;
  logic [WEIGHT_BITS-1:0] cut_q;
  logic [ConnW-1:0] conn_q;
  logic [SoedW-1:0] soed_q;
  logic [SpanW-1:0] span_m1;

  assign sum_ready_o = ~pv_q | prod_ready_i;
  assign span_m1     = sum_span_i - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (sum_ready_o) begin
      pv_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_valid_i && sum_ready_o) begin
      ctl_q  <= sum_ctl_i;
      span_q <= sum_span_i;
      cut_q  <= sum_ctl_i.cut ? sum_weight_i : '0;
      conn_q <= (sum_span_i > SpanW'(1)) ?
                ConnW'(sum_weight_i) * ConnW'(span_m1) : '0;
      soed_q <= SoedW'(sum_weight_i) * SoedW'(sum_ext_i);
    end
  end

  assign prod_valid_o = pv_q;
  assign prod_ctl_o   = ctl_q;
  assign prod_span_o  = span_q;
  assign cut_add_o    = cut_q;
  assign conn_add_o   = conn_q;
  assign soed_add_o   = soed_q;

endmodule

>>> design/hcm_sat_acc.sv
// ----------------------------------------------------------------------------
// hcm_sat_acc
// One saturating running total with a synchronous clear.
// ----------------------------------------------------------------------------
module hcm_sat_acc #(
  parameter int unsigned SUM_BITS = hcm_pkg::DefSumBits,
  parameter int unsigned ADD_BITS = hcm_pkg::DefWeightBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                clr_i,
  input  logic [ADD_BITS-1:0] add_i,
  output logic [SUM_BITS-1:0] sum_o
);
  import hcm_pkg::*;

  localparam int unsigned AccW = ((SUM_BITS > ADD_BITS) ? SUM_BITS : ADD_BITS) + 1;
  localparam logic [AccW-1:0] SumMax = AccW'({SUM_BITS{1'b1}});

  logic [SUM_BITS-1:0] sum_q;
  logic [SUM_BITS-1:0] sum_d;
  logic [AccW-1:0]     wide;

  assign wide = AccW'(sum_q) + AccW'(add_i);

  always_comb begin
    if (clr_i) begin
      sum_d = '0;
    end else if (wide > SumMax) begin
      sum_d = SUM_BITS'(SumMax);
    end else begin
      sum_d = SUM_BITS'(wide);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

>>> tb/tb_hypergraph_cut_metrics.sv
// ----------------------------------------------------------------------------
// tb_hypergraph_cut_metrics
// Streams pins of short and long nets, clear commands, global nets and
// stray pins into the cut metrics block. Each net result is checked field by
// field against totals that the bench works out on its own.
// ----------------------------------------------------------------------------
module tb_hypergraph_cut_metrics;
  timeunit 1ns;
  timeprecision 1ps;

  import hcm_pkg::*;

  // Sizes of the block as instantiated (package defaults).
  localparam int unsigned Parts     = DefParts;
  localparam int unsigned CntBits   = DefPinCountBits;
  localparam int unsigned WtBits    = DefWeightBits;
  localparam int unsigned SumBits   = DefSumBits;
  localparam logic [CntBits-1:0] CntMax = {CntBits{1'b1}};
  localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};

  // Operation codes carried on op_i.
  localparam logic OpPin   = 1'b0;
  localparam logic OpClear = 1'b1;

  // Run shape.
  localparam int unsigned RandBeats  = 950;    // random non-global beats to send
  localparam int unsigned HoldAt     = 120;    // result count that starts the long hold
  localparam int unsigned HoldCycles = 300;    // length of the long receiver hold
  localparam int unsigned TailCycles = 8;      // wait after the drain; pipeline depth is four
  localparam int unsigned StallLimit = 4000;   // cycles with no beat on either channel

  // One input beat as queued for the driver, with its own idle count and a
  // flag that makes the driver wait until every pending result is back.
  typedef struct {
    logic                    op;
    logic [PartBits-1:0]     part;
    logic                    pv;
    logic [WeightInBits-1:0] wt;
    logic                    glob;
    logic                    last;
    int unsigned             gap;
    bit                      drain;
  } pin_beat_t;

  // What one finished net must show at the output.
  typedef struct packed {
    logic                   cut;
    logic [SpanOutBits-1:0] span;
    logic [TotalBits-1:0]   cut_total;
    logic [TotalBits-1:0]   conn_total;
    logic [TotalBits-1:0]   soed_total;
  } net_totals_t;

  // DUT ports. Every input starts at a known value.
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic                    op_i         = OpPin;
  logic [PartBits-1:0]     part_i       = '0;
  logic                    part_valid_i = 1'b0;
  logic [WeightInBits-1:0] net_weight_i = '0;
  logic                    net_global_i = 1'b0;
  logic                    last_pin_i   = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic                    net_is_cut_o;
  logic [SpanOutBits-1:0]  parts_spanned_o;
  logic [TotalBits-1:0]    total_cut_o;
  logic [TotalBits-1:0]    total_connectivity_o;
  logic [TotalBits-1:0]    total_soed_o;

  hypergraph_cut_metrics u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .op_i                 (op_i),
    .part_i               (part_i),
    .part_valid_i         (part_valid_i),
    .net_weight_i         (net_weight_i),
    .net_global_i         (net_global_i),
    .last_pin_i           (last_pin_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .net_is_cut_o         (net_is_cut_o),
    .parts_spanned_o      (parts_spanned_o),
    .total_cut_o          (total_cut_o),
    .total_connectivity_o (total_connectivity_o),
    .total_soed_o         (total_soed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus store and shared bookkeeping.
  // --------------------------------------------------------------------------
  pin_beat_t   pin_q[$];
  net_totals_t net_totals_q[$];     // expected results, oldest first
  bit          gapless    = 1'b0;   // queue beats with no idle cycles
  bit          drain_next = 1'b0;   // next queued beat waits for an empty pipeline
  int unsigned errors     = 0;
  int unsigned backlog    = 0;      // pending results, as of the previous edge
  int unsigned stall_run  = 0;      // consecutive cycles with no beat moving

  // Counters for the closing summary.
  int unsigned beats_in    = 0;
  int unsigned clears_seen = 0;
  int unsigned nets_done   = 0;
  int unsigned span_peak   = 0;

  // --------------------------------------------------------------------------
  // Metrics tracker: the bench's own copy of the per-net state and totals.
  // --------------------------------------------------------------------------
  logic [4:0]         first_code = '0;
  logic               in_net     = 1'b0;
  logic               differs    = 1'b0;
  logic [Parts-1:0]   seen_parts = '0;
  logic [CntBits-1:0] part_cnt [Parts];
  logic [CntBits-1:0] max_cnt    = '0;
  logic [CntBits-1:0] pin_total  = '0;
  logic [SumBits-1:0] cut_acc    = '0;
  logic [SumBits-1:0] conn_acc   = '0;
  logic [SumBits-1:0] soed_acc   = '0;

  initial begin
    foreach (part_cnt[i]) part_cnt[i] = '0;
  end

  function automatic logic [SumBits-1:0] sat_sum(input logic [SumBits-1:0] acc,
                                                  input logic [63:0] add);
    logic [64:0] s;
    s = 65'(acc) + 65'(add);
    return (s > 65'(SumMax)) ? SumMax : s[SumBits-1:0];
  endfunction

  task automatic drop_net();
    first_code = '0;
    in_net     = 1'b0;
    differs    = 1'b0;
    seen_parts = '0;
    foreach (part_cnt[i]) part_cnt[i] = '0;
    max_cnt    = '0;
    pin_total  = '0;
  endtask

  // Folds one accepted beat into the tracker. The last pin of a net that is
  // not global queues the result that the block must produce for it.
  task automatic account_pin(input logic op, input logic [PartBits-1:0] part,
                             input logic pv, input logic [WeightInBits-1:0] wt,
                             input logic glob, input logic last);
    logic [WtBits-1:0] w;
    logic              assigned;
    logic [4:0]        code;
    int unsigned       span;
    net_totals_t       res;
    w = wt[WtBits-1:0];
    if (op == OpClear) begin
      drop_net();
      cut_acc  = '0;
      conn_acc = '0;
      soed_acc = '0;
      return;
    end
    // Global pins never enter the net; a global last pin throws it away.
    if (glob) begin
      if (last) drop_net();
      return;
    end
    // Unassigned pins carry a code of their own for the cut test.
    assigned = pv && (part < Parts);
    code     = assigned ? 5'(part) : 5'(Parts);
    if (!in_net) begin
      first_code = code;
      differs    = 1'b0;
      in_net     = 1'b1;
    end else if (code != first_code) begin
      differs = 1'b1;
    end
    if (pin_total != CntMax) pin_total++;
    if (assigned) begin
      seen_parts[part] = 1'b1;
      if (part_cnt[part] != CntMax) part_cnt[part]++;
      if (part_cnt[part] > max_cnt) max_cnt = part_cnt[part];
    end
    if (!last) return;
    span = $countones(seen_parts);
    if (differs) cut_acc = sat_sum(cut_acc, 64'(w));
    if (span > 1) conn_acc = sat_sum(conn_acc, 64'(w) * 64'(span - 1));
    soed_acc = sat_sum(soed_acc, 64'(w) * 64'(pin_total - max_cnt));
    res.cut        = differs;
    res.span       = SpanOutBits'(span);
    res.cut_total  = TotalBits'(cut_acc);
    res.conn_total = TotalBits'(conn_acc);
    res.soed_total = TotalBits'(soed_acc);
    net_totals_q.push_back(res);
    if (span > span_peak) span_peak = span;
    drop_net();
  endtask

  task automatic note_field(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: checks the output beat first, then folds the input beat in, so
  // a result can never be matched against a pin taken at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    net_totals_t want;
    if (!rst_ni) begin
      backlog <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (net_totals_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got cut %0b span %0d",
                   $time, net_is_cut_o, parts_spanned_o);
          errors++;
        end else begin
          want = net_totals_q.pop_front();
          nets_done++;
          note_field("net_is_cut", 64'(want.cut), 64'(net_is_cut_o));
          note_field("parts_spanned", 64'(want.span), 64'(parts_spanned_o));
          note_field("total_cut", 64'(want.cut_total), 64'(total_cut_o));
          note_field("total_connectivity", 64'(want.conn_total),
                     64'(total_connectivity_o));
          note_field("total_soed", 64'(want.soed_total), 64'(total_soed_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        beats_in++;
        if (op_i == OpClear) clears_seen++;
        account_pin(op_i, part_i, part_valid_i, net_weight_i, net_global_i, last_pin_i);
      end
      backlog <= net_totals_q.size();
    end
  end

  // --------------------------------------------------------------------------
  // Driver: takes beats from pin_q, idles for each beat's gap, and for a
  // draining beat holds off until the pipeline has handed back everything.
  // Valid stays high across back-to-back beats with a single assignment.
  // --------------------------------------------------------------------------
  pin_beat_t   next_beat;
  bit          offering  = 1'b0;
  bit          have_next = 1'b0;
  int unsigned gap_left  = 0;
  int unsigned settle    = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      offering  = 1'b0;
      have_next = 1'b0;
      gap_left  = 0;
      settle    = 0;
    end else begin
      if (offering && in_ready_o) offering = 1'b0;
      if (!offering && !have_next && pin_q.size() != 0) begin
        next_beat = pin_q.pop_front();
        have_next = 1'b1;
        gap_left  = next_beat.gap;
        // The backlog lags one edge, so give the last accepted beat time
        // to show up in it before trusting an empty count.
        settle    = 2;
      end
      if (!offering && have_next) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (next_beat.drain && (settle != 0 || backlog != 0)) begin
          if (settle != 0) settle--;
        end else begin
          op_i         <= next_beat.op;
          part_i       <= next_beat.part;
          part_valid_i <= next_beat.pv;
          net_weight_i <= next_beat.wt;
          net_global_i <= next_beat.glob;
          last_pin_i   <= next_beat.last;
          offering  = 1'b1;
          have_next = 1'b0;
        end
      end
      in_valid_i <= offering;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: draws a stall after every result, runs stall-free stretches,
  // and once holds ready low long enough for the block to back up into its
  // input while the driver keeps offering.
  // --------------------------------------------------------------------------
  int unsigned rx_wait = 0;
  int unsigned rx_seen = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait = 0;
      rx_seen = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        rx_seen++;
        if (rx_seen == HoldAt) rx_wait = HoldCycles;
        else if ((rx_seen / 24) % 4 == 2) rx_wait = 0;
        else rx_wait = $urandom_range(0, 11);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ready_i <= (rx_wait == 0);
    end
  end

  // Counts cycles in which no beat moves on either channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stall_run <= 0;
    else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_run <= 0;
    else stall_run <= stall_run + 1;
  end

  // --------------------------------------------------------------------------
  // Stimulus construction.
  // --------------------------------------------------------------------------
  task automatic push_beat(input logic op, input logic [PartBits-1:0] part,
                           input logic pv, input logic [WeightInBits-1:0] wt,
                           input logic glob, input logic last);
    pin_beat_t b;
    b.op    = op;
    b.part  = part;
    b.pv    = pv;
    b.wt    = wt;
    b.glob  = glob;
    b.last  = last;
    b.gap   = gapless ? 0 : $urandom_range(0, 11);
    b.drain = drain_next;
    drain_next = 1'b0;
    pin_q.push_back(b);
  endtask

  function automatic logic [WeightInBits-1:0] pick_weight();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return WeightInBits'($urandom);
  endfunction

  task automatic build_directed();
    // Single-pin net at full weight: not cut, one partition, no SOED.
    push_beat(OpPin, 4'd0, 1'b1, 16'hFFFF, 1'b0, 1'b1);
    // Highest and lowest partition in one net.
    push_beat(OpPin, 4'd15, 1'b1, 16'h1234, 1'b0, 1'b0);
    push_beat(OpPin, 4'd0, 1'b1, 16'hFFFF, 1'b0, 1'b1);
    // Only unassigned pins: same code, so uncut, but both pins are external.
    push_beat(OpPin, 4'd7, 1'b0, 16'h0005, 1'b0, 1'b0);
    push_beat(OpPin, 4'd3, 1'b0, 16'h8001, 1'b0, 1'b1);
    // Assigned followed by unassigned: cut while spanning a single partition.
    push_beat(OpPin, 4'd3, 1'b1, 16'h0000, 1'b0, 1'b0);
    push_beat(OpPin, 4'd9, 1'b0, 16'h00FF, 1'b0, 1'b1);
    // A global net is skipped entirely.
    push_beat(OpPin, 4'd2, 1'b1, 16'h4444, 1'b1, 1'b0);
    push_beat(OpPin, 4'd8, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    // A global last pin discards the partial net in front of it.
    push_beat(OpPin, 4'd5, 1'b1, 16'h0010, 1'b0, 1'b0);
    push_beat(OpPin, 4'd1, 1'b1, 16'h0020, 1'b1, 1'b1);
    push_beat(OpPin, 4'd6, 1'b1, 16'h0003, 1'b0, 1'b1);
    // Clear in the middle of a net, then a zero-weight cut net.
    push_beat(OpPin, 4'd2, 1'b1, 16'h0100, 1'b0, 1'b0);
    push_beat(OpClear, 4'd11, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    push_beat(OpPin, 4'd7, 1'b1, 16'h0200, 1'b0, 1'b0);
    push_beat(OpPin, 4'd9, 1'b1, 16'h0000, 1'b0, 1'b1);
    // A global pin inside a net is ignored.
    push_beat(OpPin, 4'd4, 1'b1, 16'h0300, 1'b0, 1'b0);
    push_beat(OpPin, 4'd1, 1'b1, 16'h0400, 1'b1, 1'b0);
    push_beat(OpPin, 4'd4, 1'b1, 16'hFFFF, 1'b0, 1'b1);
  endtask

  // Two long nets, sent back to back. The first touches every partition
  // with uneven counts and ends on an unassigned pin; the second piles all
  // of its pins onto a single partition.
  task automatic build_long_nets();
    gapless    = 1'b1;
    drain_next = 1'b1;
    for (int i = 0; i < 60; i++) push_beat(OpPin, 4'd0, 1'b1, pick_weight(), 1'b0, 1'b0);
    for (int i = 0; i < 40; i++) push_beat(OpPin, 4'd1, 1'b1, pick_weight(), 1'b0, 1'b0);
    for (int p = 2; p < Parts; p++) push_beat(OpPin, PartBits'(p), 1'b1, 16'h0001, 1'b0, 1'b0);
    push_beat(OpPin, 4'd0, 1'b0, 16'hFFFF, 1'b0, 1'b1);
    for (int i = 0; i < 80; i++) push_beat(OpPin, 4'd5, 1'b1, pick_weight(), 1'b0, 1'b0);
    push_beat(OpPin, 4'd5, 1'b1, 16'hABCD, 1'b0, 1'b1);
    gapless = 1'b0;
  endtask

  // Mostly well-formed nets with random content, some of them global, plus
  // clears and stray pins with every field random.
  task automatic build_random();
    int unsigned sent;
    int unsigned roll;
    int unsigned len;
    int unsigned spread;
    bit          drained;
    logic        glob;
    logic [PartBits-1:0] home;
    logic [PartBits-1:0] part;
    sent    = 0;
    drained = 1'b0;
    while (sent < RandBeats) begin
      gapless = ((sent / 48) % 4 == 1);
      if (!drained && sent >= RandBeats / 2) begin
        drain_next = 1'b1;
        drained    = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        push_beat(OpClear, PartBits'($urandom), 1'($urandom), WeightInBits'($urandom),
                  1'($urandom), 1'($urandom));
        sent++;
      end else if (roll < 9) begin
        glob = 1'($urandom);
        push_beat(OpPin, PartBits'($urandom), 1'($urandom), WeightInBits'($urandom),
                  glob, 1'($urandom));
        if (!glob) sent++;
      end else begin
        len    = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
        glob   = ($urandom_range(0, 11) == 0);
        home   = PartBits'($urandom);
        spread = $urandom_range(0, 2);   // one partition, a pair, or anything
        for (int k = 0; k < len; k++) begin
          case (spread)
            0: part = home;
            1: part = home ^ PartBits'($urandom_range(0, 1));
            default: part = PartBits'($urandom);
          endcase
          push_beat(OpPin, part, ($urandom_range(0, 9) != 0), pick_weight(), glob,
                    (k == len - 1));
        end
        if (!glob) sent += len;
      end
    end
    gapless = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: fill the queue, reset, wait for everything to drain.
  // --------------------------------------------------------------------------
  initial begin
    build_directed();
    build_long_nets();
    build_random();

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while ((pin_q.size() != 0 || have_next || in_valid_i || backlog != 0) &&
           stall_run < StallLimit)
      @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (stall_run >= StallLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, stall_run);
      errors++;
    end
    if (net_totals_q.size() != 0) begin
      $display("%0t: %0d net results still expected, got none", $time, net_totals_q.size());
      errors += net_totals_q.size();
    end

    $display("Run covered %0d input beats (%0d clears) and %0d checked net results,",
             beats_in, clears_seen, nets_done);
    $display("including long gapless nets and nets spanning up to %0d partitions.",
             span_peak);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
